FILE: hdl/nlgpd_pkg.sv
// ----------------------------------------------------------------------------
// nlgpd_pkg
// Shared types and constants of the nonlinear-gain PD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package nlgpd_pkg;

  localparam int ErrWidthDef = 16;
  localparam int GainW       = 16;
  localparam int LimW        = 31;
  localparam int CfgW        = 31;
  localparam int DriveW      = 32;
  localparam int IntegW      = 32;
  localparam int SumW        = 64;
  localparam int MagW        = 63;
  localparam int HugeBit     = 62;
  // divide by 1280 = shift by 8, then divide by 5
  localparam int DropW       = 8;
  localparam int QuotW       = MagW - DropW;
  localparam int Div5Const   = 5;

  localparam logic [GainW-1:0]  KpDivRst    = 16'd12800;
  localparam logic [GainW-1:0]  KiBaseRst   = 16'd26;
  localparam logic [GainW-1:0]  KdGainRst   = 16'd13;
  localparam logic [LimW-1:0]   IntLimRst   = 31'd6553600;
  localparam logic [DriveW-1:0] DrivePosMax = 32'h7FFF_FFFF;
  localparam logic [DriveW-1:0] DriveNegMax = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_KP_DIV,
    CFG_KI_BASE,
    CFG_KD_GAIN,
    CFG_INT_LIMIT
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SQUARE,
    ST_DIVK,
    ST_GAIN,
    ST_MULG,
    ST_SUM,
    ST_ABS,
    ST_DIV5,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/nonlinear_gain_pd_controller_unit.sv
// ----------------------------------------------------------------------------
// nonlinear_gain_pd_controller_unit
// PD controller with quadratic dynamic gain and a reported, clamped integral.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer condition          Content
// s_axis    in         s_axis_tvalid & tready      error sample
// m_axis    out        m_axis_tvalid & tready      drive, integral, saturated
// cfg       in         cfg_we_i                    register index and data
//
// One sample at a time: no new input transfer until the result is loaded into
// the output register. Bit-serial square, radix-2 divide by kp_divisor,
// bit-serial gain multiply and a bit-serial divide by 5 form the datapath; the
// divide by 5 is skipped when the gain product overflows. Reset clears state and loads register defaults.
// A result held in the output register does not block the next input transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module nonlinear_gain_pd_controller_unit #(
  parameter  int ERROR_WIDTH = nlgpd_pkg::ErrWidthDef,
  localparam int InW         = ((ERROR_WIDTH + 7) / 8) * 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire nlgpd_pkg::cfg_idx_e         cfg_idx_i,
  input  wire logic [nlgpd_pkg::CfgW-1:0]  cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [InW-1:0]              s_axis_tdata,   // error
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [nlgpd_pkg::DriveW+nlgpd_pkg::IntegW-1:0] m_axis_tdata, // drive, integral
  output logic [0:0]                       m_axis_tuser    // saturated
);

  import nlgpd_pkg::*;

  localparam int EW     = ERROR_WIDTH;
  localparam int DW     = 2 * EW + 16;
  localparam int MW     = EW + 2;
  localparam int PW     = DW + MW;
  localparam int SqW    = 2 * EW + 1;
  localparam int KW     = GainW + EW + 1;
  localparam int LoopN  = EW + 1;
  localparam int CntMax = (DW > QuotW) ? DW : QuotW;
  localparam int CntW   = $clog2(CntMax + 1);
  localparam int CW     = (PW > SumW) ? PW : SumW;
  localparam int IaW    = ((EW + 10 > IntegW) ? EW + 10 : IntegW) + 1;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic [GainW-1:0]    kp_div_q, ki_base_q, kd_gain_q;
  logic [LimW-1:0]     int_lim_q;

  logic [EW-1:0]       err_q, err_d;
  logic [EW-1:0]       prev_err_q, prev_err_d;
  logic [IntegW-1:0]   integ_q, integ_d;
  logic [EW-1:0]       ae_q, ae_d;
  logic                dneg_q, dneg_d;
  logic [SqW-1:0]      sq_q, sq_d;
  logic [KW-1:0]       kprod_q, kprod_d;
  logic [GainW-1:0]    rem_q, rem_d;
  logic [DW-1:0]       dvd_q, dvd_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic                huge_q, huge_d;
  logic                sneg_q, sneg_d;
  logic [QuotW-1:0]    mag5_q, mag5_d;
  logic [2:0]          rem5_q, rem5_d;

  logic                out_valid_q, out_valid_d;
  logic [DriveW-1:0]   out_drive_q, out_drive_d;
  logic [IntegW-1:0]   out_integ_q, out_integ_d;
  logic                out_sat_q, out_sat_d;

  logic                in_xfer, out_free, load_out;
  logic                last_loop, last_divk, last_mulg, last_div5;
  logic                huge_now;

  // setup terms
  logic [EW:0]         diff, abs_diff;
  logic [IaW-1:0]      ex, istep, isum, ilim, inlim, iclamp;
  // square / kd steps
  logic [EW:0]         sq_add;
  logic [GainW:0]      k_add;
  // kp divide step
  logic [GainW-1:0]    divisor;
  logic [GainW:0]      dtrial;
  logic                dge;
  // gain multiply
  logic [MW-1:0]       mult5;
  logic [DW:0]         p_add;
  // sum
  logic [CW-1:0]       pc;
  logic [SumW-1:0]     mag_ext, k4;
  // divide by 5
  logic [3:0]          t5;
  logic                ge5;
  // drive
  logic [DriveW-1:0]   drive_val;
  logic                drive_sat;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign load_out  = (state_q == ST_DONE) && out_free;
  assign last_loop = (cnt_q == CntW'(LoopN - 1));
  assign last_divk = (cnt_q == CntW'(DW - 1));
  assign last_mulg = (cnt_q == CntW'(MW - 1));
  assign last_div5 = (cnt_q == CntW'(QuotW - 1));

  assign pc       = CW'(prod_q);
  assign huge_now = pc > (CW'(1) << HugeBit);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_integ_q, out_drive_q};
  assign m_axis_tuser  = out_sat_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_SQUARE;
      ST_SQUARE: if (last_loop) state_d = ST_DIVK;
      ST_DIVK:   if (last_divk) state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_MULG;
      ST_MULG:   if (last_mulg) state_d = ST_SUM;
      ST_SUM:    state_d = huge_now ? ST_DONE : ST_ABS;
      ST_ABS:    state_d = ST_DIV5;
      ST_DIV5:   if (last_div5) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    diff     = {err_q[EW-1], err_q} - {prev_err_q[EW-1], prev_err_q};
    abs_diff = diff[EW] ? -diff : diff;

    ex     = {{(IaW-EW){err_q[EW-1]}}, err_q};
    istep  = (ex << 9) + (ex << 7) + (ex << 4) - ex;
    isum   = {{(IaW-IntegW){integ_q[IntegW-1]}}, integ_q} + istep;
    ilim   = IaW'(int_lim_q);
    inlim  = -ilim;
    if ($signed(isum) >= $signed(ilim)) begin
      iclamp = ilim;
    end else if ($signed(isum) <= $signed(inlim)) begin
      iclamp = inlim;
    end else begin
      iclamp = isum;
    end

    sq_add = sq_q[0] ? {1'b0, sq_q[SqW-1:EW+1]} + {1'b0, ae_q}
                     : {1'b0, sq_q[SqW-1:EW+1]};
    k_add  = kprod_q[0] ? {1'b0, kprod_q[KW-1:EW+1]} + {1'b0, kd_gain_q}
                        : {1'b0, kprod_q[KW-1:EW+1]};

    divisor = (kp_div_q == '0) ? GainW'(1) : kp_div_q;
    dtrial  = {rem_q, dvd_q[DW-1]};
    dge     = dtrial >= {1'b0, divisor};

    mult5 = (MW'(ae_q) << 2) + MW'(ae_q);
    p_add = prod_q[0] ? {1'b0, prod_q[PW-1:MW]} + {1'b0, dvd_q}
                      : {1'b0, prod_q[PW-1:MW]};

    mag_ext = {1'b0, pc[MagW-1:0]};
    k4      = SumW'(kprod_q) << 2;

    t5  = {rem5_q, mag5_q[QuotW-1]};
    ge5 = t5 >= 4'(Div5Const);

    drive_sat = 1'b0;
    if (huge_q) begin
      drive_sat = 1'b1;
      drive_val = err_q[EW-1] ? DriveNegMax : DrivePosMax;
    end else if (!sneg_q) begin
      if (mag5_q > QuotW'(DrivePosMax)) begin
        drive_sat = 1'b1;
        drive_val = DrivePosMax;
      end else begin
        drive_val = mag5_q[DriveW-1:0];
      end
    end else begin
      if (mag5_q > QuotW'(DriveNegMax)) begin
        drive_sat = 1'b1;
        drive_val = DriveNegMax;
      end else begin
        drive_val = -mag5_q[DriveW-1:0];
      end
    end

    cnt_d      = cnt_q;
    err_d      = err_q;
    prev_err_d = prev_err_q;
    integ_d    = integ_q;
    ae_d       = ae_q;
    dneg_d     = dneg_q;
    sq_d       = sq_q;
    kprod_d    = kprod_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    prod_d     = prod_q;
    sum_d      = sum_q;
    huge_d     = huge_q;
    sneg_d     = sneg_q;
    mag5_d     = mag5_q;
    rem5_d     = rem5_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) err_d = s_axis_tdata[EW-1:0];
      end
      ST_SETUP: begin
        ae_d       = err_q[EW-1] ? -err_q : err_q;
        dneg_d     = diff[EW];
        sq_d       = {{EW{1'b0}}, 1'b0, ae_d};
        kprod_d    = {{GainW{1'b0}}, abs_diff};
        integ_d    = iclamp[IntegW-1:0];
        prev_err_d = err_q;
        cnt_d      = '0;
      end
      ST_SQUARE: begin
        sq_d    = {sq_add, sq_q[EW:1]};
        kprod_d = {k_add, kprod_q[EW:1]};
        cnt_d   = cnt_q + 1'b1;
        if (last_loop) begin
          dvd_d = {sq_d[2*EW-1:0], {GainW{1'b0}}};
          rem_d = '0;
          cnt_d = '0;
        end
      end
      ST_DIVK: begin
        rem_d = dge ? GainW'(dtrial - {1'b0, divisor}) : dtrial[GainW-1:0];
        dvd_d = {dvd_q[DW-2:0], dge};
        cnt_d = cnt_q + 1'b1;
      end
      ST_GAIN: begin
        dvd_d  = dvd_q + DW'(ki_base_q);
        prod_d = {{DW{1'b0}}, mult5};
        cnt_d  = '0;
      end
      ST_MULG: begin
        prod_d = {p_add, prod_q[MW-1:1]};
        cnt_d  = cnt_q + 1'b1;
      end
      ST_SUM: begin
        huge_d = huge_now;
        sum_d  = (err_q[EW-1] ^ dneg_q) ? mag_ext - k4 : mag_ext + k4;
      end
      ST_ABS: begin
        sneg_d = err_q[EW-1] ^ sum_q[SumW-1];
        mag5_d = sum_q[SumW-1] ? QuotW'((-sum_q) >> DropW) : QuotW'(sum_q >> DropW);
        rem5_d = '0;
        cnt_d  = '0;
      end
      ST_DIV5: begin
        rem5_d = ge5 ? 3'(t5 - 4'(Div5Const)) : t5[2:0];
        mag5_d = {mag5_q[QuotW-2:0], ge5};
        cnt_d  = cnt_q + 1'b1;
      end
      ST_DONE: begin
        cnt_d = cnt_q;
      end
      default: begin
        cnt_d = '0;
      end
    endcase

    out_valid_d = out_valid_q;
    out_drive_d = out_drive_q;
    out_integ_d = out_integ_q;
    out_sat_d   = out_sat_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_drive_d = drive_val;
      out_integ_d = integ_q;
      out_sat_d   = drive_sat;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      kp_div_q    <= KpDivRst;
      ki_base_q   <= KiBaseRst;
      kd_gain_q   <= KdGainRst;
      int_lim_q   <= IntLimRst;
      prev_err_q  <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prev_err_q  <= prev_err_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KP_DIV:    kp_div_q  <= cfg_data_i[GainW-1:0];
          CFG_KI_BASE:   ki_base_q <= cfg_data_i[GainW-1:0];
          CFG_KD_GAIN:   kd_gain_q <= cfg_data_i[GainW-1:0];
          CFG_INT_LIMIT: int_lim_q <= cfg_data_i[LimW-1:0];
          default:       kp_div_q  <= kp_div_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    ae_q        <= ae_d;
    dneg_q      <= dneg_d;
    sq_q        <= sq_d;
    kprod_q     <= kprod_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    prod_q      <= prod_d;
    sum_q       <= sum_d;
    huge_q      <= huge_d;
    sneg_q      <= sneg_d;
    mag5_q      <= mag5_d;
    rem5_q      <= rem5_d;
    out_drive_q <= out_drive_d;
    out_integ_q <= out_integ_d;
    out_sat_q   <= out_sat_d;
  end

endmodule

`default_nettype wire
